### sv/assert_macros.svh
// Assertion helpers for the RTL; brb_back.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold on every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Condition in the cycle after a trigger.
`define ASSERT_NEXT(label, pre, post, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

### sv/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg
// Types and constants of the byte ring buffer with undo and skip.
// ----------------------------------------------------------------------------
package brb_pkg;

    localparam int FW           = 13;
    localparam int CAPACITY_DEF = 4096;
    localparam int MAX_READ_DEF = 64;
    localparam logic [FW-1:0] CFG_RESET = 13'd4096;

    localparam logic [2:0] OP_WRITE = 3'd0;
    localparam logic [2:0] OP_READ  = 3'd1;
    localparam logic [2:0] OP_UNDO  = 3'd2;
    localparam logic [2:0] OP_SKIP  = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_LEN  = 2'd1;
    localparam logic [1:0] ST_NO_SPACE = 2'd2;
    localparam logic [1:0] ST_REPAIRED = 2'd3;

    typedef struct packed {
        logic [2:0]    op;
        logic [7:0]    data_in;
        logic          first;
        logic [FW-1:0] length;
        logic [FW-1:0] rd_skip_length;
        logic          do_write;
        logic          do_read;
    } in_t;

    typedef struct packed {
        logic [1:0]    status;
        logic [7:0]    data_out;
        logic          last;
        logic [FW-1:0] used_count;
        logic [FW-1:0] total_length;
    } out_t;

    typedef enum logic [2:0] {
        K_WR_FIRST,
        K_WR_NEXT,
        K_READ,
        K_UNDO,
        K_SKIP,
        K_CLEAR,
        K_NOP
    } kind_t;

    typedef struct packed {
        kind_t kind;
        in_t   item;
    } entry_t;

endpackage

### sv/brb_ram.sv
// ----------------------------------------------------------------------------
// brb_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/brb_mod.sv
// ----------------------------------------------------------------------------
// brb_mod
// Remainder unit: one restoring step a cycle, a single step when x < 2*len.
// ----------------------------------------------------------------------------
module brb_mod #(
    parameter int LW = 13
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [LW-1:0] x,
    input  logic [LW-1:0] len,
    output logic          done,
    output logic [LW-1:0] res
);

    localparam int SW = $clog2(LW);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [LW-1:0] r_reg, r_next;
    logic [SW-1:0] s_reg, s_next;
    logic [2*LW-1:0] dv;
    logic          ge;
    logic          fast;

    always_comb
    begin
        dv   = {{LW{1'b0}}, len} << s_reg;
        ge   = {{LW{1'b0}}, r_reg} >= dv;
        fast = {1'b0, x} < {len, 1'b0};
        busy_next = busy_reg;
        done_next = 1'b0;
        r_next    = r_reg;
        s_next    = s_reg;
        if (busy_reg)
        begin
            if (ge)
            begin
                r_next = r_reg - dv[LW-1:0];
            end
            if (s_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                s_next = s_reg - 1'b1;
            end
        end
        else if (start)
        begin
            r_next    = x;
            s_next    = fast ? '0 : SW'(LW - 1);
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        s_reg <= s_next;
    end

    assign done = done_reg;
    assign res  = r_reg;

endmodule

### sv/brb_front.sv
// ----------------------------------------------------------------------------
// brb_front
// Accepts commands, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module brb_front
    import brb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  in_t    item,
    output logic   busy,
    input  logic   pop,
    output logic   entry_valid,
    output entry_t entry
);

    entry_t     q_reg [2];
    logic       head_reg, tail_reg;
    logic [1:0] cnt_reg;
    logic       push;
    kind_t      kind;

    always_comb
    begin
        case (item.op)
            OP_WRITE: kind = item.first ? K_WR_FIRST : K_WR_NEXT;
            OP_READ:  kind = K_READ;
            OP_UNDO:  kind = K_UNDO;
            OP_SKIP:  kind = K_SKIP;
            OP_CLEAR: kind = K_CLEAR;
            default:  kind = K_NOP;
        endcase
    end

    assign busy        = (cnt_reg == 2'd2);
    assign push        = start && !busy;
    assign entry_valid = (cnt_reg != 2'd0);
    assign entry       = q_reg[head_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[tail_reg] <= '{kind: kind, item: item};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= 1'b0;
            tail_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                tail_reg <= ~tail_reg;
            end
            if (pop)
            begin
                head_reg <= ~head_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

### sv/brb_back.sv
// ----------------------------------------------------------------------------
// brb_back
// Executes queued commands on the pointers, fill count and ring memory.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module brb_back
    import brb_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int MAX_READ = MAX_READ_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        entry_valid,
    input  entry_t                      entry,
    output logic                        pop,
    input  logic [$clog2(CAPACITY):0]   len,
    output logic                        ram_we,
    output logic [$clog2(CAPACITY)-1:0] ram_waddr,
    output logic [7:0]                  ram_wdata,
    output logic [$clog2(CAPACITY)-1:0] ram_raddr,
    input  logic [7:0]                  ram_rdata,
    output logic                        strobe,
    output out_t                        result
);

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = AW + 1;
    localparam int WW = ((LW > FW) ? LW : FW) + 1;
    localparam int KW = $clog2(MAX_READ + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_MWAIT = 4'b0100,
        S_READ  = 4'b1000
    } state_t;

    typedef enum logic [7:0] {
        PH_WRITE   = 8'b0000_0001,
        PH_RDFIRST = 8'b0000_0010,
        PH_UWA     = 8'b0000_0100,
        PH_UWB     = 8'b0000_1000,
        PH_URA     = 8'b0001_0000,
        PH_URB     = 8'b0010_0000,
        PH_SKW     = 8'b0100_0000,
        PH_SKR     = 8'b1000_0000
    } phase_t;

    state_t        state_reg, state_next;
    phase_t        ph_reg, ph_next;
    entry_t        cur_reg, cur_next;
    logic [AW-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [AW-1:0] pwp_reg, pwp_next, prp_reg, prp_next;
    logic [LW-1:0] fill_reg, fill_next;
    logic [FW-1:0] mrem_reg, mrem_next;
    logic          macc_reg, macc_next;
    logic [1:0]    st_reg, st_next;
    logic [AW-1:0] ta_reg, ta_next, rn_reg, rn_next, ra_reg, ra_next;
    logic [KW-1:0] k_reg, k_next, rlen_reg, rlen_next;
    logic          rd_pend_reg, rd_pend_next, rd_last_reg, rd_last_next;
    logic          res_valid_reg, res_valid_next;
    out_t          res_reg, res_next;

    logic          mod_start, mod_done;
    logic [LW-1:0] mod_x, mod_res;

    brb_mod #(.LW(LW)) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .x     (mod_x),
        .len   (len),
        .done  (mod_done),
        .res   (mod_res)
    );

    always_comb
    begin
        logic [WW-1:0] len_w, fill_w, lng_w, rds_w;
        logic [LW-1:0] dsum, xsum, ra_inc, ra_adv;
        logic          emit;
        logic [1:0]    emit_st;
        logic [FW-1:0] mrem_dec;

        len_w  = WW'(len);
        fill_w = WW'(fill_reg);
        lng_w  = WW'(cur_reg.item.length);
        rds_w  = WW'(cur_reg.item.rd_skip_length);
        dsum   = '0;
        xsum   = '0;
        ra_inc = LW'(ra_reg) + 1'b1;
        ra_adv = '0;
        emit   = 1'b0;
        emit_st  = st_reg;
        mrem_dec = mrem_reg - 1'b1;

        state_next = state_reg;
        ph_next    = ph_reg;
        cur_next   = cur_reg;
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        pwp_next   = pwp_reg;
        prp_next   = prp_reg;
        fill_next  = fill_reg;
        mrem_next  = mrem_reg;
        macc_next  = macc_reg;
        st_next    = st_reg;
        ta_next    = ta_reg;
        rn_next    = rn_reg;
        ra_next    = ra_reg;
        k_next     = k_reg;
        rlen_next  = rlen_reg;
        rd_pend_next = 1'b0;
        rd_last_next = 1'b0;
        pop        = 1'b0;
        mod_start  = 1'b0;
        mod_x      = '0;
        ram_we     = 1'b0;
        ram_waddr  = wp_reg;
        ram_wdata  = cur_reg.item.data_in;
        ram_raddr  = ra_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (entry_valid)
                begin
                    pop        = 1'b1;
                    cur_next   = entry;
                    st_next    = ST_OK;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_IDLE;
                case (cur_reg.kind)
                    K_WR_FIRST:
                    begin
                        mrem_next = '0;
                        macc_next = 1'b0;
                        if (cur_reg.item.length == '0)
                        begin
                            emit    = 1'b1;
                            emit_st = ST_BAD_LEN;
                        end
                        else if (fill_w + lng_w > len_w)
                        begin
                            mrem_next = cur_reg.item.length - 1'b1;
                            emit      = 1'b1;
                            emit_st   = ST_NO_SPACE;
                        end
                        else
                        begin
                            pwp_next   = wp_reg;
                            mrem_next  = cur_reg.item.length - 1'b1;
                            macc_next  = (cur_reg.item.length != FW'(1));
                            ram_we     = 1'b1;
                            fill_next  = fill_reg + 1'b1;
                            mod_start  = 1'b1;
                            mod_x      = LW'(wp_reg) + 1'b1;
                            ph_next    = PH_WRITE;
                            state_next = S_MWAIT;
                        end
                    end

                    K_WR_NEXT:
                    begin
                        if (mrem_reg == '0)
                        begin
                            emit    = 1'b1;
                            emit_st = ST_BAD_LEN;
                        end
                        else
                        begin
                            mrem_next = mrem_dec;
                            if (mrem_dec == '0)
                            begin
                                macc_next = 1'b0;
                            end
                            if (macc_reg && (fill_reg < len))
                            begin
                                ram_we     = 1'b1;
                                fill_next  = fill_reg + 1'b1;
                                mod_start  = 1'b1;
                                mod_x      = LW'(wp_reg) + 1'b1;
                                ph_next    = PH_WRITE;
                                state_next = S_MWAIT;
                            end
                            else
                            begin
                                emit    = 1'b1;
                                emit_st = ST_NO_SPACE;
                            end
                        end
                    end

                    K_READ:
                    begin
                        if ((cur_reg.item.length == '0) || (lng_w > WW'(MAX_READ)))
                        begin
                            emit    = 1'b1;
                            emit_st = ST_BAD_LEN;
                        end
                        else if (fill_w < lng_w)
                        begin
                            wp_next   = '0;
                            rp_next   = '0;
                            pwp_next  = '0;
                            prp_next  = '0;
                            fill_next = '0;
                            emit      = 1'b1;
                            emit_st   = ST_NO_SPACE;
                        end
                        else
                        begin
                            prp_next   = rp_reg;
                            fill_next  = fill_reg - LW'(cur_reg.item.length);
                            rlen_next  = KW'(cur_reg.item.length);
                            mod_start  = 1'b1;
                            mod_x      = LW'(rp_reg) + 1'b1;
                            ph_next    = PH_RDFIRST;
                            state_next = S_MWAIT;
                        end
                    end

                    K_UNDO:
                    begin
                        if (cur_reg.item.do_write)
                        begin
                            mrem_next  = '0;
                            macc_next  = 1'b0;
                            mod_start  = 1'b1;
                            mod_x      = LW'(wp_reg);
                            ph_next    = PH_UWA;
                            state_next = S_MWAIT;
                        end
                        else if (cur_reg.item.do_read)
                        begin
                            mod_start  = 1'b1;
                            mod_x      = LW'(rp_reg);
                            ph_next    = PH_URA;
                            state_next = S_MWAIT;
                        end
                        else
                        begin
                            emit = 1'b1;
                        end
                    end

                    K_SKIP:
                    begin
                        if ((lng_w > len_w) || (rds_w > len_w))
                        begin
                            emit    = 1'b1;
                            emit_st = ST_BAD_LEN;
                        end
                        else if ((cur_reg.item.do_write && (fill_w + lng_w > len_w))
                                 || (cur_reg.item.do_read && (fill_w < rds_w)))
                        begin
                            emit    = 1'b1;
                            emit_st = ST_NO_SPACE;
                        end
                        else
                        begin
                            fill_next = LW'(fill_w
                                + (cur_reg.item.do_write ? lng_w : '0)
                                - (cur_reg.item.do_read ? rds_w : '0));
                            if (cur_reg.item.do_write)
                            begin
                                pwp_next = wp_reg;
                            end
                            if (cur_reg.item.do_read)
                            begin
                                prp_next = rp_reg;
                            end
                            if (cur_reg.item.do_write)
                            begin
                                mod_start  = 1'b1;
                                mod_x      = LW'(wp_reg) + LW'(cur_reg.item.length);
                                ph_next    = PH_SKW;
                                state_next = S_MWAIT;
                            end
                            else if (cur_reg.item.do_read)
                            begin
                                mod_start  = 1'b1;
                                mod_x      = LW'(rp_reg) + LW'(cur_reg.item.rd_skip_length);
                                ph_next    = PH_SKR;
                                state_next = S_MWAIT;
                            end
                            else
                            begin
                                emit = 1'b1;
                            end
                        end
                    end

                    K_CLEAR:
                    begin
                        wp_next   = '0;
                        rp_next   = '0;
                        pwp_next  = '0;
                        prp_next  = '0;
                        fill_next = '0;
                        mrem_next = '0;
                        macc_next = 1'b0;
                        emit      = 1'b1;
                    end

                    default:
                    begin
                        emit = 1'b1;
                    end
                endcase
            end

            S_MWAIT:
            begin
                if (mod_done)
                begin
                    case (ph_reg)
                        PH_WRITE:
                        begin
                            wp_next    = AW'(mod_res);
                            emit       = 1'b1;
                            state_next = S_IDLE;
                        end

                        PH_RDFIRST:
                        begin
                            rn_next    = AW'(mod_res);
                            ra_next    = rp_reg;
                            k_next     = '0;
                            state_next = S_READ;
                        end

                        PH_UWA:
                        begin
                            ta_next   = AW'(mod_res);
                            mod_start = 1'b1;
                            mod_x     = LW'(pwp_reg);
                            ph_next   = PH_UWB;
                        end

                        PH_UWB:
                        begin
                            dsum = LW'(ta_reg) + len - mod_res;
                            if (dsum >= len)
                            begin
                                dsum = dsum - len;
                            end
                            if (fill_reg < dsum)
                            begin
                                xsum = LW'(ta_reg) + len - fill_reg;
                                if (xsum >= len)
                                begin
                                    xsum = xsum - len;
                                end
                                wp_next   = AW'(xsum);
                                pwp_next  = AW'(xsum);
                                fill_next = '0;
                                st_next   = ST_REPAIRED;
                                emit_st   = ST_REPAIRED;
                            end
                            else
                            begin
                                fill_next = fill_reg - dsum;
                                wp_next   = pwp_reg;
                            end
                            if (cur_reg.item.do_read)
                            begin
                                mod_start = 1'b1;
                                mod_x     = LW'(rp_reg);
                                ph_next   = PH_URA;
                            end
                            else
                            begin
                                emit       = 1'b1;
                                state_next = S_IDLE;
                            end
                        end

                        PH_URA:
                        begin
                            ta_next   = AW'(mod_res);
                            mod_start = 1'b1;
                            mod_x     = LW'(prp_reg);
                            ph_next   = PH_URB;
                        end

                        PH_URB:
                        begin
                            dsum = LW'(ta_reg) + len - mod_res;
                            if (dsum >= len)
                            begin
                                dsum = dsum - len;
                            end
                            if (fill_w + WW'(dsum) > len_w)
                            begin
                                fill_next = len;
                                emit_st   = ST_REPAIRED;
                            end
                            else
                            begin
                                fill_next = fill_reg + dsum;
                            end
                            rp_next    = prp_reg;
                            emit       = 1'b1;
                            state_next = S_IDLE;
                        end

                        PH_SKW:
                        begin
                            wp_next = AW'(mod_res);
                            if (cur_reg.item.do_read)
                            begin
                                mod_start = 1'b1;
                                mod_x     = LW'(rp_reg) + LW'(cur_reg.item.rd_skip_length);
                                ph_next   = PH_SKR;
                            end
                            else
                            begin
                                emit       = 1'b1;
                                state_next = S_IDLE;
                            end
                        end

                        PH_SKR:
                        begin
                            rp_next    = AW'(mod_res);
                            emit       = 1'b1;
                            state_next = S_IDLE;
                        end

                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                ra_adv = (k_reg == '0) ? LW'(rn_reg)
                                       : ((ra_inc == len) ? '0 : ra_inc);
                rd_pend_next = 1'b1;
                rd_last_next = (k_reg == rlen_reg - 1'b1);
                ra_next      = AW'(ra_adv);
                rp_next      = AW'(ra_adv);
                k_next       = k_reg + 1'b1;
                if (k_reg == rlen_reg - 1'b1)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res_valid_next        = emit;
        res_next.status       = emit_st;
        res_next.data_out     = 8'd0;
        res_next.last         = 1'b1;
        res_next.used_count   = FW'(fill_next);
        res_next.total_length = FW'(len);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ph_reg        <= PH_WRITE;
            wp_reg        <= '0;
            rp_reg        <= '0;
            pwp_reg       <= '0;
            prp_reg       <= '0;
            fill_reg      <= '0;
            mrem_reg      <= '0;
            macc_reg      <= 1'b0;
            st_reg        <= ST_OK;
            k_reg         <= '0;
            rlen_reg      <= '0;
            rd_pend_reg   <= 1'b0;
            rd_last_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ph_reg        <= ph_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            pwp_reg       <= pwp_next;
            prp_reg       <= prp_next;
            fill_reg      <= fill_next;
            mrem_reg      <= mrem_next;
            macc_reg      <= macc_next;
            st_reg        <= st_next;
            k_reg         <= k_next;
            rlen_reg      <= rlen_next;
            rd_pend_reg   <= rd_pend_next;
            rd_last_reg   <= rd_last_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        ta_reg  <= ta_next;
        rn_reg  <= rn_next;
        ra_reg  <= ra_next;
        res_reg <= res_next;
    end

    always_comb
    begin
        strobe = rd_pend_reg || res_valid_reg;
        if (rd_pend_reg)
        begin
            result.status       = ST_OK;
            result.data_out     = ram_rdata;
            result.last         = rd_last_reg;
            result.used_count   = FW'(fill_reg);
            result.total_length = FW'(len);
        end
        else
        begin
            result = res_reg;
        end
    end

    `ASSERT_ALWAYS(a_fill_range, fill_reg <= LW'(CAPACITY), "fill count above capacity")
    `ASSERT_ALWAYS(a_one_source, !(rd_pend_reg && res_valid_reg), "two results in one cycle")
    `ASSERT_NEXT(a_read_last, (state_reg == S_READ) && (k_reg == rlen_reg - 1'b1), rd_last_reg && rd_pend_reg && (state_reg == S_IDLE), "read burst did not end")

endmodule

### sv/byte_ring_buffer_undo_skip.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer_undo_skip
// Byte ring buffer with all-or-nothing message writes, burst reads, undo
// and skip.
// ----------------------------------------------------------------------------
// Commands enter on item when start is high and busy is low; a two-entry
// queue sits between the front end and the executing back end, so busy rises
// only when two commands wait. Results leave on result, one per cycle with
// strobe high; the receiver takes every result as it comes and cannot stall.
// A read of N bytes gives N results on consecutive cycles, the first one
// after its remainder pass, the S_MWAIT and S_READ states and the registered
// RAM read; every other command gives a single result. A command makes one
// pass of the remainder unit per pointer it moves: a single restoring step
// when the value stays below twice the ring length, else a full restoring
// pass over every result bit. Undo runs two passes per side.
// Ring length is written through the APB port at address 0; the user must
// write it only while idle, since the block itself does not enforce it.
// Reset empties the ring and sets the length to 4096; ring memory contents
// are left as they are.
// ----------------------------------------------------------------------------
module byte_ring_buffer_undo_skip
    import brb_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int MAX_READ = MAX_READ_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  in_t         item,
    output logic        busy,
    output logic        strobe,
    output out_t        result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = AW + 1;
    localparam int WW = ((LW > FW) ? LW : FW) + 1;

    logic [FW-1:0] buf_reg;
    logic [LW-1:0] len;
    logic          pop, entry_valid;
    entry_t        entry;
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {{(32-FW){1'b0}}, buf_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg <= CFG_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == 1'b0))
        begin
            buf_reg <= pwdata[FW-1:0];
        end
    end

    always_comb
    begin
        if (buf_reg == '0)
        begin
            len = LW'(1);
        end
        else if (WW'(buf_reg) > WW'(CAPACITY))
        begin
            len = LW'(CAPACITY);
        end
        else
        begin
            len = LW'(buf_reg);
        end
    end

    brb_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .item        (item),
        .busy        (busy),
        .pop         (pop),
        .entry_valid (entry_valid),
        .entry       (entry)
    );

    brb_ram #(.WIDTH(8), .DEPTH(CAPACITY)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    brb_back #(.CAPACITY(CAPACITY), .MAX_READ(MAX_READ)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_valid (entry_valid),
        .entry       (entry),
        .pop         (pop),
        .len         (len),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .strobe      (strobe),
        .result      (result)
    );

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the byte ring buffer with undo and skip. Commands
// are predicted in order as they are queued; every result word is compared
// in full, all fields at once, against the predicted stream. The ring length register is
// changed over APB between phases, extremes and clamped values included.
// ----------------------------------------------------------------------------
module testbench;
    import brb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IN_W = $bits(in_t);

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    in_t         item = '0;
    logic        busy;
    logic        strobe;
    out_t        result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    in_t  cmd_queue[$];
    out_t expected_words[$];

    bit [7:0]    ring_copy[CAPACITY_DEF];
    bit          ring_written[CAPACITY_DEF];
    int unsigned wr_ptr, rd_ptr, prev_wr_ptr, prev_rd_ptr, fill, msg_left;
    bit          msg_taken;
    int unsigned ring_len_reg = 4096;

    int errors = 0;
    int words_checked = 0;
    int cmds_sent = 0;
    int cycle = 0;

    byte_ring_buffer_undo_skip i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .item(item), .busy(busy),
        .strobe(strobe), .result(result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned ring_len();
        if (ring_len_reg < 1) return 1;
        if (ring_len_reg > CAPACITY_DEF) return CAPACITY_DEF;
        return ring_len_reg;
    endfunction

    function automatic int unsigned ring_dist(int unsigned from, int unsigned to,
                                              int unsigned n);
        return (to % n + n - from % n) % n;
    endfunction

    function automatic void push_word(logic [1:0] st, logic [7:0] d, logic lst);
        out_t w;
        w.status       = st;
        w.data_out     = d;
        w.last         = lst;
        w.used_count   = fill[FW-1:0];
        w.total_length = FW'(ring_len());
        expected_words.push_back(w);
    endfunction

    function automatic logic [1:0] put_byte(logic [7:0] b, int unsigned n);
        if (fill >= n) return ST_NO_SPACE;
        ring_copy[wr_ptr]    = b;
        ring_written[wr_ptr] = 1'b1;
        wr_ptr = (wr_ptr + 1) % n;
        fill++;
        return ST_OK;
    endfunction

    function automatic void empty_ring();
        wr_ptr = 0; rd_ptr = 0; prev_wr_ptr = 0; prev_rd_ptr = 0; fill = 0;
    endfunction

    function automatic bit read_is_safe(int unsigned cnt);
        int unsigned p;
        p = rd_ptr;
        for (int i = 0; i < cnt; i++)
        begin
            if (!ring_written[p]) return 1'b0;
            p = (p + 1) % ring_len();
        end
        return 1'b1;
    endfunction

    function automatic void predict_ring(in_t c);
        int unsigned n, d, cnt;
        logic [1:0]  st;
        n  = ring_len();
        st = ST_OK;
        cnt = c.length;
        case (c.op)
            OP_WRITE:
            begin
                if (c.first)
                begin
                    msg_left  = 0;
                    msg_taken = 1'b0;
                    if (cnt == 0) st = ST_BAD_LEN;
                    else if (fill + cnt > n)
                    begin
                        st = ST_NO_SPACE;
                        msg_left = cnt - 1;
                    end
                    else
                    begin
                        prev_wr_ptr = wr_ptr;
                        msg_taken = 1'b1;
                        msg_left = cnt - 1;
                        st = put_byte(c.data_in, n);
                    end
                end
                else if (msg_left == 0) st = ST_BAD_LEN;
                else
                begin
                    msg_left--;
                    st = msg_taken ? put_byte(c.data_in, n) : ST_NO_SPACE;
                end
                if (msg_left == 0) msg_taken = 1'b0;
            end
            OP_READ:
            begin
                if (cnt == 0 || cnt > MAX_READ_DEF) st = ST_BAD_LEN;
                else if (fill < cnt)
                begin
                    empty_ring();
                    st = ST_NO_SPACE;
                end
                else
                begin
                    prev_rd_ptr = rd_ptr;
                    fill -= cnt;
                    for (int i = 0; i < cnt; i++)
                    begin
                        push_word(ST_OK, ring_copy[rd_ptr], i + 1 == cnt);
                        rd_ptr = (rd_ptr + 1) % n;
                    end
                    return;
                end
            end
            OP_UNDO:
            begin
                if (c.do_write)
                begin
                    d = ring_dist(prev_wr_ptr, wr_ptr, n);
                    if (fill < d)
                    begin
                        wr_ptr = (wr_ptr % n + n - fill % n) % n;
                        prev_wr_ptr = wr_ptr;
                        fill = 0;
                        st = ST_REPAIRED;
                    end
                    else
                    begin
                        fill -= d;
                        wr_ptr = prev_wr_ptr;
                    end
                    msg_left = 0;
                    msg_taken = 1'b0;
                end
                if (c.do_read)
                begin
                    d = ring_dist(prev_rd_ptr, rd_ptr, n);
                    if (fill + d > n)
                    begin
                        fill = n;
                        st = ST_REPAIRED;
                    end
                    else fill += d;
                    rd_ptr = prev_rd_ptr;
                end
            end
            OP_SKIP:
            begin
                if (cnt > n || c.rd_skip_length > n) st = ST_BAD_LEN;
                else if ((c.do_write && fill + cnt > n) ||
                         (c.do_read && fill < c.rd_skip_length)) st = ST_NO_SPACE;
                else
                begin
                    if (c.do_write)
                    begin
                        prev_wr_ptr = wr_ptr;
                        fill += cnt;
                        wr_ptr = (wr_ptr + cnt) % n;
                    end
                    if (c.do_read)
                    begin
                        prev_rd_ptr = rd_ptr;
                        fill -= c.rd_skip_length;
                        rd_ptr = (rd_ptr + c.rd_skip_length) % n;
                    end
                end
            end
            OP_CLEAR:
            begin
                empty_ring();
                msg_left = 0;
                msg_taken = 1'b0;
            end
            default: ;
        endcase
        push_word(st, 8'd0, 1'b1);
    endfunction

    // turn reads that would touch never-written ring entries into zero-length reads
    function automatic void queue_cmd(in_t c);
        if (c.op == OP_READ && c.length >= 1 && c.length <= MAX_READ_DEF &&
            fill >= c.length && !read_is_safe(c.length))
            c.length = '0;
        predict_ring(c);
        cmd_queue.push_back(c);
        cmds_sent++;
    endfunction

    function automatic in_t make_cmd(logic [2:0] op, int unsigned len,
                                     int unsigned rskip, int unsigned dw,
                                     int unsigned dr);
        in_t c;
        c = '0;
        c.op = op;
        c.data_in = 8'($urandom);
        c.length = FW'(len);
        c.rd_skip_length = FW'(rskip);
        c.do_write = dw[0];
        c.do_read = dr[0];
        return c;
    endfunction

    function automatic void queue_message(int unsigned len, int unsigned sent);
        in_t c;
        c = make_cmd(OP_WRITE, len, $urandom, $urandom, $urandom);
        c.first = 1'b1;
        queue_cmd(c);
        for (int i = 1; i < sent; i++)
        begin
            c = make_cmd(OP_WRITE, $urandom, $urandom, $urandom, $urandom);
            queue_cmd(c);
        end
    endfunction

    function automatic void queue_random(int target);
        int unsigned sel, len;
        in_t c;
        int stop;
        stop = cmds_sent + target;
        while (cmds_sent < stop)
        begin
            sel = $urandom_range(99);
            if (sel < 45)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(ring_len() + 4, 1)
                                                : $urandom_range(24, 1);
                if (len > 40) queue_message(len, $urandom_range(40, 1));
                else if ($urandom_range(9) == 0) queue_message(len, $urandom_range(len, 1));
                else queue_message(len, len);
            end
            else if (sel < 68)
                queue_cmd(make_cmd(OP_READ, ($urandom_range(19) == 0) ?
                          $urandom_range(8191) : $urandom_range(MAX_READ_DEF, 1),
                          $urandom, $urandom, $urandom));
            else if (sel < 78)
                queue_cmd(make_cmd(OP_UNDO, $urandom, $urandom, $urandom, $urandom));
            else if (sel < 88)
                queue_cmd(make_cmd(OP_SKIP, $urandom_range(12), $urandom_range(12),
                                   $urandom, $urandom));
            else if (sel < 91)
                queue_cmd(make_cmd(OP_CLEAR, $urandom, $urandom, $urandom, $urandom));
            else
            begin
                c = IN_W'({$urandom, $urandom});
                queue_cmd(c);
            end
        end
    endfunction

    task automatic drain();
        while (cmd_queue.size() != 0 || start || expected_words.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_ring_len(int unsigned v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= '0;
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        ring_len_reg = v & 32'h1FFF;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            cycle <= 0;
        end
        else
        begin
            cycle <= cycle + 1;
            if (start && !busy) void'(cmd_queue.pop_front());
            if (cmd_queue.size() != 0 &&
                ((cycle > 3000 && cycle < 6000) || $urandom_range(99) >= 28))
            begin
                start <= 1'b1;
                item  <= cmd_queue[0];
            end
            else start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (expected_words.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected word %p", result);
            end
            else
            begin
                if (result !== expected_words[0])
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %p got %p", expected_words[0], result);
                end
                void'(expected_words.pop_front());
                words_checked++;
            end
        end
    end

    initial
    begin
        in_t c;
        int unsigned lens[6];
        lens = '{16, 0, 8191, 100, 5000, 4096};
        empty_ring();
        msg_left = 0;
        msg_taken = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        write_ring_len(4096);

        // directed: message, empty and stray writes, reads, undo, skip, clear, unknown op
        queue_message(3, 3);
        queue_cmd(make_cmd(OP_WRITE, 0, 0, 0, 0));
        c = make_cmd(OP_WRITE, 0, 0, 0, 0);
        c.first = 1'b1;
        c.data_in = 8'hFF;
        queue_cmd(c);
        queue_cmd(make_cmd(OP_READ, 2, 0, 0, 0));
        queue_cmd(make_cmd(OP_READ, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_READ, 65, 0, 0, 0));
        queue_cmd(make_cmd(OP_UNDO, 0, 0, 0, 1));
        queue_cmd(make_cmd(OP_UNDO, 0, 0, 1, 0));
        queue_cmd(make_cmd(OP_UNDO, 0, 0, 1, 1));
        queue_message(8191, 3);
        queue_message(2, 2);
        queue_cmd(make_cmd(OP_READ, 64, 0, 0, 0));
        queue_cmd(make_cmd(OP_SKIP, 8191, 8191, 1, 1));
        queue_cmd(make_cmd(OP_SKIP, 4096, 0, 1, 0));
        queue_cmd(make_cmd(OP_SKIP, 0, 4096, 0, 1));
        queue_cmd(make_cmd(OP_SKIP, 4, 2, 1, 1));
        queue_cmd(make_cmd(OP_UNDO, 0, 0, 1, 1));
        queue_cmd(make_cmd(OP_CLEAR, 8191, 8191, 1, 1));
        queue_cmd(make_cmd(3'd7, 8191, 8191, 1, 1));
        queue_random(80);
        drain();

        foreach (lens[k])
        begin
            write_ring_len(lens[k]);
            queue_random((lens[k] == 0) ? 40 : 75);
            drain();
        end

        $display("%0d commands sent, %0d result words checked over 7 ring lengths",
                 cmds_sent, words_checked);
        if (errors == 0 && expected_words.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
